[src/pse_pkg.sv]
// Shared definitions for the palette screen effect block.
// Register indexes, field widths, configuration bundle and channel math.
// No dependencies.
package pse_pkg;

  localparam int CH_W        = 4;
  localparam int NUM_CH      = 3;
  localparam int IDX_W       = 6;
  localparam int COLOR_W     = CH_W * NUM_CH;
  localparam int TDATA_W     = 24;
  localparam int LEVEL_W     = 8;
  localparam int STRENGTH_W  = 6;
  localparam int BRIGHT_W    = 17;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = BRIGHT_W;
  localparam int MAX_ENTRIES = 64;

  localparam logic [BRIGHT_W-1:0] BRIGHT_ONE = 17'h10000;
  localparam logic [FRAC_W:0]     ROUND_HALF = 17'h08000;
  localparam logic [CH_W-1:0]     CH_MAX     = 4'd15;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUM_MASK    = 3'd0,
    REG_HEALTH_FX   = 3'd1,
    REG_SHIELD_FX   = 3'd2,
    REG_FLASH_FX    = 3'd3,
    REG_FX_ENABLE   = 3'd4,
    REG_BRIGHTNESS  = 3'd5,
    REG_BRIGHT_EN   = 3'd6
  } reg_idx_t;

  // Channel positions: red, green, blue
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic [NUM_CH-1:0]   lum_mask;
    logic [LEVEL_W-1:0]  health_fx;
    logic [LEVEL_W-1:0]  shield_fx;
    logic [LEVEL_W-1:0]  flash_fx;
    logic                fx_enable;
    logic [BRIGHT_W-1:0] brightness;
    logic                brightness_enable;
  } cfg_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             oob;
    rgb_t             ch;
  } stage_t;

  // Scale a channel by k/64, truncated
  function automatic logic [CH_W-1:0] scale_k(input logic [CH_W-1:0] c,
                                              input logic [STRENGTH_W-1:0] k);
    logic [CH_W+STRENGTH_W-1:0] prod;
    prod = {{CH_W{1'b0}}, k} * {{STRENGTH_W{1'b0}}, c};
    return prod[CH_W+STRENGTH_W-1:STRENGTH_W];
  endfunction

  // Scale a channel by a 0.16 fraction with round to nearest
  function automatic logic [CH_W-1:0] scale_bright(input logic [CH_W-1:0] c,
                                                   input logic [FRAC_W-1:0] b);
    logic [CH_W+FRAC_W:0] prod;
    prod = {{(CH_W+1){1'b0}}, b} * {{(FRAC_W+1){1'b0}}, c};
    prod = prod + (CH_W+FRAC_W+1)'(ROUND_HALF);
    return prod[CH_W+FRAC_W-1:FRAC_W];
  endfunction

endpackage

[src/pse_pipe.sv]
// Three-stage color pipeline: luminance, tint, brightness.
// Depends on pse_pkg; configuration comes in as a pse_pkg::cfg_t bundle.
module pse_pipe #(
  parameter int MAX_ENTRIES = pse_pkg::MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pse_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pse_pkg::IDX_W-1:0]    in_idx,
  input  logic [pse_pkg::COLOR_W-1:0]  in_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pse_pkg::IDX_W-1:0]    out_idx,
  output logic [pse_pkg::COLOR_W-1:0]  out_color
);

  logic v1, v2, v3;
  pse_pkg::stage_t s1, s2, s3;
  pse_pkg::stage_t s1_next, s2_next, s3_next;
  logic adv1, adv2, adv3;

  // Each stage moves when it is empty or the next one moves
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage one: luminance
  logic [pse_pkg::CH_W-1:0] r_in, g_in, b_in, lum;
  always_comb begin
    b_in = in_color[pse_pkg::CH_W-1:0];
    g_in = in_color[2*pse_pkg::CH_W-1:pse_pkg::CH_W];
    r_in = in_color[3*pse_pkg::CH_W-1:2*pse_pkg::CH_W];
    lum  = (r_in >> 2) + (g_in >> 1) + (b_in >> 2);
    s1_next.idx = in_idx;
    s1_next.oob = ({1'b0, in_idx} >= (pse_pkg::IDX_W+1)'(MAX_ENTRIES));
    s1_next.ch[pse_pkg::CH_RED]   = r_in;
    s1_next.ch[pse_pkg::CH_GREEN] = g_in;
    s1_next.ch[pse_pkg::CH_BLUE]  = b_in;
    if (cfg.lum_mask != '0) begin
      for (int i = 0; i < pse_pkg::NUM_CH; i++) begin
        s1_next.ch[i] = cfg.lum_mask[i] ? lum : '0;
      end
    end
  end

  // Stage two: tint, health over shield over flash
  logic                              fx_on;
  logic [pse_pkg::LEVEL_W-1:0]       level;
  logic [pse_pkg::NUM_CH-1:0]        tint_sel;
  logic [pse_pkg::STRENGTH_W-1:0]    k;
  always_comb begin
    fx_on = cfg.fx_enable &&
            ((cfg.health_fx | cfg.shield_fx | cfg.flash_fx) != '0);
    if (cfg.health_fx != '0) begin
      level    = cfg.health_fx;
      tint_sel = 3'b001;
    end else if (cfg.shield_fx != '0) begin
      level    = cfg.shield_fx;
      tint_sel = 3'b010;
    end else begin
      level    = cfg.flash_fx;
      tint_sel = 3'b100;
    end
    k = ~level[pse_pkg::STRENGTH_W-1:0];
    s2_next = s1;
    if (fx_on) begin
      for (int i = 0; i < pse_pkg::NUM_CH; i++) begin
        if (tint_sel[i]) begin
          s2_next.ch[i] = pse_pkg::CH_MAX -
                          pse_pkg::scale_k(pse_pkg::CH_MAX - s1.ch[i], k);
        end else begin
          s2_next.ch[i] = pse_pkg::scale_k(s1.ch[i], k);
        end
      end
    end
  end

  // Stage three: brightness below one, rounded; out-of-range entries zeroed
  logic bright_on;
  always_comb begin
    bright_on = cfg.brightness_enable && (cfg.brightness < pse_pkg::BRIGHT_ONE);
    s3_next = s2;
    if (bright_on) begin
      for (int i = 0; i < pse_pkg::NUM_CH; i++) begin
        s3_next.ch[i] = pse_pkg::scale_bright(s2.ch[i],
                                              cfg.brightness[pse_pkg::FRAC_W-1:0]);
      end
    end
    if (s2.oob) begin
      s3_next.ch = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
  end

  assign out_valid = v3;
  assign out_idx   = s3.idx;
  // Red in the top nibble, blue in the bottom
  assign out_color = {s3.ch[pse_pkg::CH_RED], s3.ch[pse_pkg::CH_GREEN],
                      s3.ch[pse_pkg::CH_BLUE]};

  // An empty output stage never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v3 |-> in_ready)
    else $error("input stalled with an empty output stage");

  // A transfer at the input lands in stage one
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted item missing from stage one");

  // A blocked middle stage keeps its item
  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    (v2 && !adv3) |=> (v2 && $stable(s2)))
    else $error("stage two item lost under stall");

  // Out-of-range entries leave with a zero color
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2.oob && adv3) |=> (out_color == '0))
    else $error("out-of-range entry produced a color");

endmodule

[src/palette_screen_effect.sv]
// Palette screen effect: luminance, tint and brightness on 12-bit palette entries.
// Top level: configuration registers and stream ports around pse_pipe.
// Depends on pse_pkg and pse_pipe.
//
// Usage:
//   Input stream (s_*): one palette entry per transfer, entry index and
//   4:4:4 base color. Output stream (m_*): one result per entry, in order,
//   same index with the processed color.
//   Configuration: write cfg_data to register cfg_index when cfg_we is high;
//   write only while no entry is in flight.
// Stages: three register stages (luminance, tint, brightness; the last one
//   is the output). An accepted entry passes through each stage in that
//   order before m_tvalid rises for it.
// Throughput: one entry per cycle while m_tready stays high; the tint and
//   brightness multipliers each sit in their own stage.
// Reset: pipeline empties, registers return to zero except brightness,
//   which returns to one (no scaling).
// Stall: when m_tready is low the result holds; earlier stages keep filling
//   until every stage is full, then s_tready drops. Nothing is dropped.
module palette_screen_effect #(
  parameter int MAX_ENTRIES = pse_pkg::MAX_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pse_pkg::TDATA_W-1:0]      s_tdata,  // entry_index[5:0], base_color[17:6]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pse_pkg::TDATA_W-1:0]      m_tdata   // out_index[5:0], out_color[17:6]
);

  pse_pkg::cfg_t cfg;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lum_mask          <= '0;
      cfg.health_fx         <= '0;
      cfg.shield_fx         <= '0;
      cfg.flash_fx          <= '0;
      cfg.fx_enable         <= 1'b0;
      cfg.brightness        <= pse_pkg::BRIGHT_ONE;
      cfg.brightness_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pse_pkg::REG_LUM_MASK:   cfg.lum_mask   <= cfg_data[pse_pkg::NUM_CH-1:0];
        pse_pkg::REG_HEALTH_FX:  cfg.health_fx  <= cfg_data[pse_pkg::LEVEL_W-1:0];
        pse_pkg::REG_SHIELD_FX:  cfg.shield_fx  <= cfg_data[pse_pkg::LEVEL_W-1:0];
        pse_pkg::REG_FLASH_FX:   cfg.flash_fx   <= cfg_data[pse_pkg::LEVEL_W-1:0];
        pse_pkg::REG_FX_ENABLE:  cfg.fx_enable  <= cfg_data[0];
        pse_pkg::REG_BRIGHTNESS: cfg.brightness <= cfg_data[pse_pkg::BRIGHT_W-1:0];
        pse_pkg::REG_BRIGHT_EN:  cfg.brightness_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [pse_pkg::IDX_W-1:0]   out_index;
  logic [pse_pkg::COLOR_W-1:0] out_color;

  pse_pipe #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_idx    (s_tdata[pse_pkg::IDX_W-1:0]),
    .in_color  (s_tdata[pse_pkg::IDX_W+pse_pkg::COLOR_W-1:pse_pkg::IDX_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_idx   (out_index),
    .out_color (out_color)
  );

  // Pack result, zero-fill to whole bytes
  assign m_tdata = {{(pse_pkg::TDATA_W-pse_pkg::IDX_W-pse_pkg::COLOR_W){1'b0}},
                    out_color, out_index};

endmodule
